/* hdl/zlema_pkg.sv */
// Shared types and constants for the zero-lag EMA filter.
package zlema_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 18;
    localparam int LAG_W    = 7;
    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_LAG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;

    localparam logic [LAG_W-1:0]    LAG_RESET    = 7'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd21845;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [RESULT_W-1:0] result_t;

    // Per-item control decided at accept time.
    typedef struct packed {
        logic filt;    // filtered result
        logic load;    // ring just filled: seed previous value with oldest sample
        logic bypass;  // single-entry ring: past is the sample itself
    } item_ctl_t;

endpackage

/* hdl/zlema_in_if.sv */
// Sample channel: valid/ready handshake carrying one input item.
interface zlema_in_if;
    logic                valid;
    logic                ready;
    zlema_pkg::sample_t  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/zlema_out_if.sv */
// Result channel: valid/ready handshake carrying one result item.
interface zlema_out_if;
    logic                valid;
    logic                ready;
    zlema_pkg::result_t  filtered;
    logic                is_filtered;

    modport source (output valid, output filtered, output is_filtered, input ready);
    modport sink   (input valid, input filtered, input is_filtered, output ready);
endinterface

/* hdl/zero_lag_ema_filter_core.sv */
// Zero-lag EMA filter top level: config registers, ring control, two-stage pipeline.
// Result path: ring read in the first stage, then EMA update into the result register.
// Throughput: one item per cycle; a stalled result holds the pipeline, bounded by the
// update loop through the previous-value register.
// Reset: config returns to lag 2 / weight 21845, pointer, fill count, ready flag and
// previous value clear; ring contents are not cleared and are never read before written.
module zero_lag_ema_filter_core #(
    parameter int MAX_LAG = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    zlema_in_if.sink                            samples,
    zlema_out_if.source                         results,
    input  logic                                cfg_we,
    input  logic [zlema_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [zlema_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_LAG + 1;
    localparam int AW    = $clog2(MAX_LAG + 1);
    localparam int CW    = $clog2(MAX_LAG + 2);

    logic [zlema_pkg::LAG_W-1:0]    cfg_lag_reg;
    logic [zlema_pkg::WEIGHT_W-1:0] cfg_weight_reg;
    logic                           cfg_hit;

    logic [AW-1:0] wp_reg;
    logic [CW-1:0] fill_reg;
    logic          rdy_reg;
    zlema_pkg::result_t prev_reg;

    logic                  a_valid_reg;
    zlema_pkg::sample_t    a_sample_reg;
    zlema_pkg::item_ctl_t  a_ctl_reg;

    logic                  b_valid_reg;
    zlema_pkg::result_t    b_filtered_reg;
    logic                  b_flag_reg;

    logic [AW-1:0] lag_eff;
    logic [CW-1:0] cap;
    logic [AW-1:0] wp_eff;
    logic [AW-1:0] wp_next;
    logic [CW-1:0] fill_next;
    logic          accept;
    logic          b_free;
    logic          a_go;
    zlema_pkg::item_ctl_t ctl_next;
    zlema_pkg::sample_t   ring_rdata;
    zlema_pkg::sample_t   past;
    zlema_pkg::result_t   ema;

    assign cfg_hit = cfg_we && ((cfg_index == zlema_pkg::REG_LAG) ||
                                (cfg_index == zlema_pkg::REG_WEIGHT));

    always_comb
    begin
        lag_eff   = (32'(cfg_lag_reg) > 32'(MAX_LAG)) ? AW'(MAX_LAG) : AW'(cfg_lag_reg);
        cap       = CW'(lag_eff) + CW'(1);
        wp_eff    = (wp_reg <= lag_eff) ? wp_reg : '0;
        wp_next   = (wp_eff == lag_eff) ? '0 : wp_eff + AW'(1);
        fill_next = (fill_reg < cap) ? fill_reg + CW'(1) : fill_reg;
        ctl_next.filt   = rdy_reg;
        ctl_next.load   = !rdy_reg && (fill_next == cap);
        ctl_next.bypass = (lag_eff == '0);
    end

    assign b_free = !b_valid_reg || results.ready;
    assign a_go   = a_valid_reg && b_free;
    assign samples.ready = !a_valid_reg || b_free;
    assign accept = samples.valid && samples.ready;

    zlema_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_eff),
        .wdata (samples.sample),
        .re    (accept),
        .raddr (wp_next),
        .rdata (ring_rdata)
    );

    assign past = a_ctl_reg.bypass ? a_sample_reg : ring_rdata;

    zlema_calc u_calc (
        .sample (a_sample_reg),
        .past   (past),
        .prev   (prev_reg),
        .weight (cfg_weight_reg),
        .result (ema)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_lag_reg    <= zlema_pkg::LAG_RESET;
            cfg_weight_reg <= zlema_pkg::WEIGHT_RESET;
            wp_reg         <= '0;
            fill_reg       <= '0;
            rdy_reg        <= 1'b0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == zlema_pkg::REG_LAG)
            begin
                cfg_lag_reg <= cfg_data[zlema_pkg::LAG_W-1:0];
            end
            else
            begin
                cfg_weight_reg <= cfg_data[zlema_pkg::WEIGHT_W-1:0];
            end
            fill_reg <= '0;
            rdy_reg  <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            if (ctl_next.load)
            begin
                rdy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_ctl_reg   <= '0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
            a_ctl_reg   <= ctl_next;
        end
        else if (a_go)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg <= samples.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            prev_reg    <= '0;
        end
        else if (a_go)
        begin
            b_valid_reg <= 1'b1;
            if (a_ctl_reg.filt)
            begin
                prev_reg <= ema;
            end
            else if (a_ctl_reg.load)
            begin
                prev_reg <= {{2{past[15]}}, past};
            end
        end
        else if (results.ready)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            b_filtered_reg <= a_ctl_reg.filt ? ema : {{2{a_sample_reg[15]}}, a_sample_reg};
            b_flag_reg     <= a_ctl_reg.filt;
        end
    end

    assign results.valid       = b_valid_reg;
    assign results.filtered    = b_filtered_reg;
    assign results.is_filtered = b_flag_reg;

    // stalled item in the ring-read stage keeps its sample
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_free) |=> (a_valid_reg && $stable(a_sample_reg)))
        else $error("ring stage item lost while stalled");

    // fill count never exceeds the ring length
    fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap)
        else $error("fill count beyond ring length");

    // previous value moves only when an item enters the result stage
    prev_only_on_go: assert property (@(posedge clk) disable iff (!rst_n)
        !a_go |=> $stable(prev_reg))
        else $error("previous value changed without an item");

    // a staged item is never both seeding and filtered
    ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> !(a_ctl_reg.filt && a_ctl_reg.load))
        else $error("item marked both seed and filtered");

endmodule

/* hdl/zlema_ring.sv */
// Delay ring storage: one write port, one registered read port.
module zlema_ring #(
    parameter int DEPTH = 65,
    parameter int AW    = 7
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  zlema_pkg::sample_t wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output zlema_pkg::sample_t rdata
);

    zlema_pkg::sample_t mem [DEPTH];
    zlema_pkg::sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/zlema_calc.sv */
// EMA update: alpha*(2*s - past - prev) + prev*65536, rounded, floored, saturated.
module zlema_calc (
    input  zlema_pkg::sample_t                sample,
    input  zlema_pkg::sample_t                past,
    input  zlema_pkg::result_t                prev,
    input  logic [zlema_pkg::WEIGHT_W-1:0]    weight,
    output zlema_pkg::result_t                result
);

    logic [zlema_pkg::WEIGHT_W-1:0] alpha;
    logic signed [18:0] s_x;
    logic signed [18:0] p_x;
    logic signed [18:0] prev_x;
    logic signed [18:0] diff;
    logic signed [18:0] alpha_x;
    logic signed [37:0] prod;
    logic signed [38:0] acc;
    logic signed [22:0] q;

    always_comb
    begin
        alpha   = (weight > zlema_pkg::WEIGHT_ONE) ? zlema_pkg::WEIGHT_ONE : weight;
        s_x     = {{3{sample[15]}}, sample};
        p_x     = {{3{past[15]}}, past};
        prev_x  = {prev[17], prev};
        diff    = (s_x <<< 1) - p_x - prev_x;
        alpha_x = {2'b00, alpha};
        prod    = alpha_x * diff;
        acc     = {prod[37], prod} + {{5{prev[17]}}, prev, 16'd0} + 39'sd32768;
        q       = acc[38:16];
        if (q > 23'sd131071)
        begin
            result = 18'sd131071;
        end
        else if (q < -23'sd131072)
        begin
            result = -18'sd131072;
        end
        else
        begin
            result = q[17:0];
        end
    end

endmodule
